@@ rtl/core/tlbpt_pkg.sv @@
package tlbpt_pkg;

  localparam int VA_W     = 32;   // request address width
  localparam int ADDR_W   = 16;   // translated part of the address
  localparam int FRAME_W  = 8;    // frame number width
  localparam int NFF_W    = 9;    // free-frame counter, wraps at 512

  localparam int TLB_ENTRIES_DEF = 16;
  localparam int PAGE_COUNT_DEF  = 256;
  localparam int OFFSET_BITS_DEF = 8;

  // Number of conditional-subtract steps needed to fold a vw-bit page
  // field into 0..pc-1. Zero when the page field already fits.
  function automatic int reduce_steps(input int pc, input int vw);
    int n;
    n = 0;
    while ((pc << n) < (1 << vw)) begin
      n = n + 1;
    end
    return n;
  endfunction

endpackage

@@ rtl/core/tlbpt_ifs.sv @@
interface tlbpt_req_if;
  import tlbpt_pkg::*;

  logic            valid;
  logic            ready;
  logic [VA_W-1:0] virtual_address;

  modport source (output valid, output virtual_address, input ready);
  modport sink (input valid, input virtual_address, output ready);
endinterface

interface tlbpt_rsp_if;
  import tlbpt_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] physical_address;
  logic              tlb_hit;
  logic              page_fault;

  modport source (output valid, output physical_address, output tlb_hit,
                  output page_fault, input ready);
  modport sink (input valid, input physical_address, input tlb_hit,
                input page_fault, output ready);
endinterface

@@ rtl/core/tlbpt_lru.sv @@
module tlbpt_lru #(
  parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
  parameter int PG_W        = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [PG_W-1:0]              page,
  input  logic                         commit,
  input  logic [tlbpt_pkg::FRAME_W-1:0] new_frame,
  output logic                         hit,
  output logic [tlbpt_pkg::FRAME_W-1:0] hit_frame
);
  import tlbpt_pkg::*;

  localparam int TW = $clog2(TLB_ENTRIES);

  logic [TLB_ENTRIES-1:0] vld_r, vld_nxt;
  logic [PG_W-1:0]        tag_r [TLB_ENTRIES];
  logic [PG_W-1:0]        tag_nxt [TLB_ENTRIES];
  logic [FRAME_W-1:0]     frm_r [TLB_ENTRIES];
  logic [FRAME_W-1:0]     frm_nxt [TLB_ENTRIES];

  logic [TW-1:0] hit_idx;
  logic [TW-1:0] upto;

  // first matching slot wins (slot 0 is most recent)
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (!hit && vld_r[i] && (tag_r[i] == page)) begin
        hit     = 1'b1;
        hit_idx = TW'(i);
      end
    end
  end

  assign hit_frame = frm_r[hit_idx];
  assign upto      = hit ? hit_idx : TW'(TLB_ENTRIES - 1);

  // slots 0..upto-1 slide down one place, new entry lands in slot 0
  always_comb begin
    vld_nxt = vld_r;
    for (int k = 0; k < TLB_ENTRIES; k++) begin
      tag_nxt[k] = tag_r[k];
      frm_nxt[k] = frm_r[k];
    end
    if (commit) begin
      for (int k = 1; k < TLB_ENTRIES; k++) begin
        if (TW'(k) <= upto) begin
          vld_nxt[k] = vld_r[k-1];
          tag_nxt[k] = tag_r[k-1];
          frm_nxt[k] = frm_r[k-1];
        end
      end
      vld_nxt[0] = 1'b1;
      tag_nxt[0] = page;
      frm_nxt[0] = new_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < TLB_ENTRIES; k++) begin
      tag_r[k] <= tag_nxt[k];
      frm_r[k] <= frm_nxt[k];
    end
  end

endmodule

@@ rtl/core/tlb_page_table_translator.sv @@
// Channel   Dir  Payload                                   Handshake
// in_chan   in   virtual_address[31:0]                     valid/ready
// out_chan  out  physical_address[15:0], tlb_hit, page_fault  valid/ready
//
// Accept in idle (page-table read issued), then resolve (TLB search, LRU shift,
// page-table write-back on a fault, result loaded) before the next accept.
// If PAGE_COUNT does not cover the page field, the page number is folded by
// one conditional subtract per cycle, then the folded page is read before resolve.
// After reset a clearing pass empties the page table;
// in_chan.ready stays low meanwhile.
// A full result register with out_chan.ready low holds the block in resolve.
module tlb_page_table_translator #(
  parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
  parameter int PAGE_COUNT  = tlbpt_pkg::PAGE_COUNT_DEF,
  parameter int OFFSET_BITS = tlbpt_pkg::OFFSET_BITS_DEF
) (
  input logic          clk,
  input logic          rst_n,
  tlbpt_req_if.sink    in_chan,
  tlbpt_rsp_if.source  out_chan
);
  import tlbpt_pkg::*;

  localparam int VPN_W = ADDR_W - OFFSET_BITS;
  localparam int PG_W  = $clog2(PAGE_COUNT);
  localparam int QB    = reduce_steps(PAGE_COUNT, VPN_W);
  localparam int SC_W  = (QB > 1) ? $clog2(QB) : 1;
  localparam int SUB_W = VPN_W + 1;
  localparam int MEM_W = FRAME_W + 1;

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_REDUCE  = 3'd2;
  localparam logic [2:0] S_READ    = 3'd3;
  localparam logic [2:0] S_RESOLVE = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [PG_W-1:0]        clr_r, clr_nxt;
  logic [NFF_W-1:0]       nff_r, nff_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [VPN_W-1:0]       vpn_r, vpn_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [SC_W-1:0]        step_r, step_nxt;
  logic [ADDR_W-1:0]      out_pa_r, out_pa_nxt;
  logic                   out_hit_r, out_hit_nxt;
  logic                   out_fault_r, out_fault_nxt;

  logic [MEM_W-1:0] pmap_mem [PAGE_COUNT];
  logic [MEM_W-1:0] pm_rd_r;

  logic                   accept;
  logic [VPN_W-1:0]       in_vpn;
  logic [OFFSET_BITS-1:0] in_off;
  logic [PG_W-1:0]        page;
  logic [PG_W-1:0]        rd_addr;
  logic [PG_W-1:0]        wr_addr;
  logic [MEM_W-1:0]       wr_data;
  logic                   wr_en;
  logic                   out_free;
  logic                   commit;
  logic                   tlb_hit;
  logic [FRAME_W-1:0]     tlb_frame;
  logic                   pm_vld;
  logic                   fault;
  logic [FRAME_W-1:0]     frame;
  logic [SUB_W-1:0]       sub_val;

  assign in_vpn = in_chan.virtual_address[ADDR_W-1:OFFSET_BITS];
  assign in_off = in_chan.virtual_address[OFFSET_BITS-1:0];
  assign page   = PG_W'(vpn_r);

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;

  assign out_free = !out_valid_r || out_chan.ready;
  assign commit   = (state_r == S_RESOLVE) && out_free;

  tlbpt_lru #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .PG_W        (PG_W)
  ) u_lru (
    .clk       (clk),
    .rst_n     (rst_n),
    .page      (page),
    .commit    (commit),
    .new_frame (frame),
    .hit       (tlb_hit),
    .hit_frame (tlb_frame)
  );

  // page-table entry: valid bit on top of the frame number
  assign pm_vld = pm_rd_r[FRAME_W];
  assign fault  = !tlb_hit && !pm_vld;
  assign frame  = tlb_hit ? tlb_frame :
                  (pm_vld ? pm_rd_r[FRAME_W-1:0] : nff_r[FRAME_W-1:0]);

  assign sub_val = SUB_W'(PAGE_COUNT) << step_r;

  // read address comes straight off the request when no folding is needed
  assign rd_addr = (state_r == S_IDLE) ? PG_W'(in_vpn) : page;
  assign wr_en   = (state_r == S_CLEAR) || (commit && fault);
  assign wr_addr = (state_r == S_CLEAR) ? clr_r : page;
  assign wr_data = (state_r == S_CLEAR) ? '0 : {1'b1, frame};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pmap_mem[wr_addr] <= wr_data;
    end
    pm_rd_r <= pmap_mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    nff_nxt       = nff_r;
    out_valid_nxt = out_valid_r;
    vpn_nxt       = vpn_r;
    off_nxt       = off_r;
    step_nxt      = step_r;
    out_pa_nxt    = out_pa_r;
    out_hit_nxt   = out_hit_r;
    out_fault_nxt = out_fault_r;

    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == PG_W'(PAGE_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          vpn_nxt   = in_vpn;
          off_nxt   = in_off;
          step_nxt  = SC_W'(QB - 1);
          state_nxt = (QB == 0) ? S_RESOLVE : S_REDUCE;
        end
      end
      S_REDUCE: begin
        if ({1'b0, vpn_r} >= sub_val) begin
          vpn_nxt = VPN_W'({1'b0, vpn_r} - sub_val);
        end
        if (step_r == '0) begin
          state_nxt = S_READ;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      S_READ: begin
        state_nxt = S_RESOLVE;
      end
      S_RESOLVE: begin
        if (commit) begin
          out_valid_nxt = 1'b1;
          out_pa_nxt    = ADDR_W'({frame, off_r});
          out_hit_nxt   = tlb_hit;
          out_fault_nxt = fault;
          if (fault) begin
            nff_nxt = nff_r + 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      nff_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      nff_r       <= nff_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vpn_r       <= vpn_nxt;
    off_r       <= off_nxt;
    step_r      <= step_nxt;
    out_pa_r    <= out_pa_nxt;
    out_hit_r   <= out_hit_nxt;
    out_fault_r <= out_fault_nxt;
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.physical_address = out_pa_r;
  assign out_chan.tlb_hit          = out_hit_r;
  assign out_chan.page_fault       = out_fault_r;

  a_result_from_resolve: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_RESOLVE))
    else $error("result appeared without a resolve step");

  a_hit_excludes_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_fault_r))
    else $error("TLB hit reported together with a page fault");

  a_alloc_only_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (nff_r != $past(nff_r)) |-> (out_valid_r && out_fault_r))
    else $error("free frame consumed without a faulting result");

endmodule

@@ test/tlb_page_table_translator_test.sv @@
module tlb_page_table_translator_test;
  import tlbpt_pkg::*;

  localparam int TLB_N    = TLB_ENTRIES_DEF;
  localparam int PAGES    = PAGE_COUNT_DEF;
  localparam int OFF_W    = OFFSET_BITS_DEF;
  localparam int PAGE_W   = ADDR_W - OFF_W;
  localparam int HOT_N    = 24;
  localparam int N_PHASE  = 4;
  localparam int PHASE_SZ = 475;
  localparam int STUCK_LIMIT = 4000;

  typedef struct packed {
    logic [ADDR_W-1:0] pa;
    logic              hit;
    logic              fault;
  } translation_t;

  typedef struct packed {
    logic [VA_W-1:0] va;
    bit              known;
    translation_t    want;
  } stim_row_t;

  localparam int N_DIRECTED = 24;

  // Pages 2..17 fill the TLB and push out pages 0, 0xFF and 1.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{32'h0000_0000, 1'b1, '{16'h0000, 1'b0, 1'b1}},  // first request faults, frame 0
    '{32'hFFFF_00FF, 1'b1, '{16'h00FF, 1'b1, 1'b0}},  // high bits dropped, hit
    '{32'h0000_FFFF, 1'b1, '{16'h01FF, 1'b0, 1'b1}},
    '{32'hABCD_FF00, 1'b1, '{16'h0100, 1'b1, 1'b0}},
    '{32'h1234_0180, 1'b1, '{16'h0280, 1'b0, 1'b1}},
    '{32'h5555_0255, 1'b0, '0},
    '{32'hAAAA_03AA, 1'b0, '0},
    '{32'h8000_0401, 1'b0, '0},
    '{32'h7FFF_05FE, 1'b0, '0},
    '{32'h0001_0610, 1'b0, '0},
    '{32'hF0F0_07EF, 1'b0, '0},
    '{32'h0F0F_0833, 1'b0, '0},
    '{32'hC3C3_09CC, 1'b0, '0},
    '{32'h3C3C_0A77, 1'b0, '0},
    '{32'h9999_0B88, 1'b0, '0},
    '{32'h6666_0C00, 1'b0, '0},
    '{32'hDEAD_0DFF, 1'b0, '0},
    '{32'hBEEF_0E5A, 1'b0, '0},
    '{32'h0000_0FA5, 1'b0, '0},
    '{32'hFFFF_1080, 1'b0, '0},
    '{32'h1357_1107, 1'b0, '0},
    '{32'h2468_0A10, 1'b0, '0},                        // hit in the middle of the LRU order
    '{32'h0000_0042, 1'b1, '{16'h0042, 1'b0, 1'b0}},  // evicted, found in page table
    '{32'hFFFF_FF55, 1'b1, '{16'h0155, 1'b0, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst_n;

  tlbpt_req_if in_chan();
  tlbpt_rsp_if out_chan();

  tlb_page_table_translator DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #6 clk = ~clk;

  // translator state as predicted
  bit          tlb_ok [TLB_N];
  int          tlb_page [TLB_N];
  logic [7:0]  tlb_frame [TLB_N];
  bit          pt_ok [PAGES];
  logic [7:0]  pt_frame [PAGES];
  logic [8:0]  free_frame = '0;

  translation_t pending_translations[$];
  int           hot_pages [HOT_N];
  int           tx_idle_pct = 0;
  int           rx_stall_pct = 0;
  int           n_fail = 0;
  int           n_hits = 0;
  int           n_walks = 0;
  int           n_faults = 0;
  int           n_checked = 0;
  int           stuck_cycles = 0;

  function automatic translation_t translate_va(input logic [VA_W-1:0] va);
    int           pg;
    int           off;
    int           slot;
    int           upto;
    int           k;
    logic [7:0]   fr;
    translation_t t;
    pg   = (int'(va[ADDR_W-1:0]) >> OFF_W) % PAGES;
    off  = int'(va[ADDR_W-1:0]) & ((1 << OFF_W) - 1);
    slot = TLB_N;
    t    = '0;
    for (k = 0; k < TLB_N; k++) begin
      if (tlb_ok[k] && tlb_page[k] == pg) begin
        slot = k;
        break;
      end
    end
    if (slot < TLB_N) begin
      t.hit = 1'b1;
      fr    = tlb_frame[slot];
      upto  = slot;
    end else begin
      if (pt_ok[pg]) begin
        fr = pt_frame[pg];
      end else begin
        t.fault      = 1'b1;
        fr           = free_frame[7:0];
        pt_ok[pg]    = 1'b1;
        pt_frame[pg] = fr;
        free_frame   = free_frame + 9'd1;
      end
      upto = TLB_N - 1;
    end
    // LRU shift; invalid entries move along like valid ones
    for (k = upto; k > 0; k--) begin
      tlb_ok[k]    = tlb_ok[k-1];
      tlb_page[k]  = tlb_page[k-1];
      tlb_frame[k] = tlb_frame[k-1];
    end
    tlb_ok[0]    = 1'b1;
    tlb_page[0]  = pg;
    tlb_frame[0] = fr;
    t.pa = ADDR_W'((int'(fr) << OFF_W) + off);
    return t;
  endfunction

  function automatic logic [VA_W-1:0] pick_va();
    logic [VA_W-1:0] va;
    int              roll;
    int              pg;
    va   = $urandom();
    roll = $urandom_range(99);
    if (roll < 45) begin
      pg = hot_pages[$urandom_range(11)];
    end else if (roll < 75) begin
      pg = hot_pages[$urandom_range(HOT_N - 1)];
    end else begin
      pg = $urandom_range(PAGES - 1);
    end
    va[ADDR_W-1:OFF_W] = PAGE_W'(pg);
    return va;
  endfunction

  task automatic queue_expected(input translation_t t);
    pending_translations.insert(pending_translations.size(), t);
  endtask

  task automatic issue_request(input logic [VA_W-1:0] va, input bit known,
                               input translation_t typed);
    translation_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid           <= 1'b1;
    in_chan.virtual_address <= va;
    do @(posedge clk); while (!in_chan.ready);
    predicted = translate_va(va);
    queue_expected(known ? typed : predicted);
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (pending_translations.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin : check_results
    translation_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_translations.size() == 0) begin
        $error("unexpected result: physical_address %h tlb_hit %b page_fault %b",
               out_chan.physical_address, out_chan.tlb_hit, out_chan.page_fault);
        n_fail++;
      end else begin
        want = pending_translations.pop_front();
        n_checked++;
        if (out_chan.physical_address !== want.pa) begin
          $error("physical_address: expected %h, got %h", want.pa, out_chan.physical_address);
          n_fail++;
        end
        if (out_chan.tlb_hit !== want.hit) begin
          $error("tlb_hit: expected %b, got %b", want.hit, out_chan.tlb_hit);
          n_fail++;
        end
        if (out_chan.page_fault !== want.fault) begin
          $error("page_fault: expected %b, got %b", want.fault, out_chan.page_fault);
          n_fail++;
        end
        if (want.hit) n_hits++;
        else if (want.fault) n_faults++;
        else n_walks++;
      end
    end
  end

  // watchdog: cycles without any accepted request or result
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_translations.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int tx_pcts [N_PHASE];
    int rx_pcts [N_PHASE];
    int p;
    int n;
    int k;
    tx_pcts = '{0, 68, 0, 12};
    rx_pcts = '{0, 0, 68, 12};
    rst_n                   <= 1'b0;
    in_chan.valid           <= 1'b0;
    in_chan.virtual_address <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < N_DIRECTED; n++) begin
      issue_request(directed_rows[n].va, directed_rows[n].known, directed_rows[n].want);
    end
    drain_results();

    for (p = 0; p < N_PHASE; p++) begin
      tx_idle_pct  = tx_pcts[p];
      rx_stall_pct = rx_pcts[p];
      for (k = 0; k < HOT_N; k++) hot_pages[k] = $urandom_range(PAGES - 1);
      for (n = 0; n < PHASE_SZ; n++) issue_request(pick_va(), 1'b0, '0);
      // sender holds off until the block has answered everything
      drain_results();
    end

    rx_stall_pct = 0;
    repeat (16) @(posedge clk);
    $display("checked %0d translations: %0d TLB hits, %0d page-table walks, %0d page faults",
             n_checked, n_hits, n_walks, n_faults);
    $display("frames handed out: %0d; idle and stall mixes on both channels", free_frame);
    if (n_fail == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/tlbpt_pkg.sv
rtl/core/tlbpt_ifs.sv
rtl/core/tlbpt_lru.sv
rtl/core/tlb_page_table_translator.sv
test/tlb_page_table_translator_test.sv
